// ----- hw/rtl/rbap_pkg.sv -----
package rbap_pkg;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int MIN_BYTES       = 4;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [3:0] ST_OK             = 4'd0;
    localparam logic [3:0] ST_FORMAT         = 4'd1;
    localparam logic [3:0] ST_NO_STAR        = 4'd2;
    localparam logic [3:0] ST_BAD_COUNT      = 4'd3;
    localparam logic [3:0] ST_NOT_DOLLAR     = 4'd4;
    localparam logic [3:0] ST_BAD_LENGTH     = 4'd5;
    localparam logic [3:0] ST_LEN_MISMATCH   = 4'd6;
    localparam logic [3:0] ST_JUNK           = 4'd7;
    localparam logic [3:0] ST_COUNT_MISMATCH = 4'd8;

    // up to two results per input byte: a data or end result and a status
    typedef struct packed {
        logic       has_data;
        logic [1:0] kind;
        logic [7:0] data;
        logic [15:0] element;
        logic       has_status;
        logic [3:0] status;
    } action_t;

endpackage

// ----- hw/rtl/resp_bulk_array_parser_core.sv -----
// channel  | dir | tdata (low bit up)                     | tuser    | tlast
// s_       | in  | in_byte[7:0]                           | -        | in_final
// m_       | out | out_byte, out_element, out_status, pad | out_kind | out_run_end
// one byte per cycle unless the output stalls or a byte yields two results; a byte
// that yields an element result and the final status sends both in turn over the single output port
// front decodes a byte per cycle into a two-entry queue while it has room, back serialises it
// aresetn synchronous active low, clears parser state and queue
module resp_bulk_array_parser_core #(
    parameter int COUNT_BITS  = rbap_pkg::COUNT_BITS_DEF,
    parameter int LENGTH_BITS = rbap_pkg::LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_byte, out_element, out_status
    output logic [1:0]  m_tuser,   // out_kind
    output logic        m_tlast
);

    logic              f_valid, f_ready, q_valid, q_ready;
    rbap_pkg::action_t f_act, q_act;

    rbap_front #(.COUNT_BITS(COUNT_BITS), .LENGTH_BITS(LENGTH_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata), .in_final(s_tlast),
        .act_valid(f_valid), .act_ready(f_ready), .act(f_act)
    );

    rbap_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_act),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_act)
    );

    rbap_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .act_valid(q_valid), .act_ready(q_ready), .act(q_act),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule

// ----- hw/rtl/rbap_front.sv -----
module rbap_front #(
    parameter int COUNT_BITS  = rbap_pkg::COUNT_BITS_DEF,
    parameter int LENGTH_BITS = rbap_pkg::LENGTH_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_final,
    output logic             act_valid,
    input  logic             act_ready,
    output rbap_pkg::action_t act
);

    typedef enum logic [3:0] {
        PH_STAR, PH_COUNT, PH_COUNT_LF, PH_DOLLAR, PH_LEN,
        PH_LEN_LF, PH_DATA, PH_DATA_LF, PH_DONE, PH_IGNORE
    } phase_t;

    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             err_reg, err_next;
    logic [2:0]             seen_reg, seen_next;
    logic [COUNT_BITS-1:0]  dcount_reg, dcount_next;
    logic [COUNT_BITS-1:0]  done_reg, done_next;
    logic [LENGTH_BITS-1:0] dlen_reg, dlen_next;
    logic [LENGTH_BITS:0]   rlen_reg, rlen_next;
    logic                   dig_reg, dig_next;
    logic                   act_valid_reg;
    rbap_pkg::action_t      act_reg, act_next;

    logic                   take;
    logic                   is_dig;
    logic [3:0]             dval;
    logic [COUNT_BITS+3:0]  cprod;
    logic [LENGTH_BITS+3:0] lprod;
    logic [3:0]             fin_st;

    assign in_ready  = !act_valid_reg || act_ready;
    assign take      = in_valid && in_ready;
    assign act_valid = act_valid_reg;
    assign act       = act_reg;
    assign is_dig    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    assign dval      = in_byte[3:0];
    // x*10 as shifts and add, overflow checked on the widened result
    assign cprod = {1'b0, dcount_reg, 3'b0} + {3'b0, dcount_reg, 1'b0}
                 + {{COUNT_BITS{1'b0}}, dval};
    assign lprod = {1'b0, dlen_reg, 3'b0} + {3'b0, dlen_reg, 1'b0}
                 + {{LENGTH_BITS{1'b0}}, dval};

    always_comb begin
        phase_next  = phase_reg;
        err_next    = err_reg;
        seen_next   = (seen_reg < 3'(rbap_pkg::MIN_BYTES)) ? seen_reg + 3'd1 : seen_reg;
        dcount_next = dcount_reg;
        done_next   = done_reg;
        dlen_next   = dlen_reg;
        rlen_next   = rlen_reg;
        dig_next    = dig_reg;
        act_next    = '0;
        act_next.element = 16'(done_reg);
        if (err_reg == rbap_pkg::ST_OK) begin
            unique case (phase_reg)
                PH_STAR: begin
                    if (in_byte == rbap_pkg::CH_STAR) begin
                        phase_next = PH_COUNT; dcount_next = '0; dig_next = 1'b0;
                    end else err_next = rbap_pkg::ST_NO_STAR;
                end
                PH_COUNT: begin
                    if (is_dig) begin
                        dcount_next = cprod[COUNT_BITS-1:0];
                        dig_next = 1'b1;
                        if (cprod[COUNT_BITS+3:COUNT_BITS] != '0)
                            err_next = rbap_pkg::ST_BAD_COUNT;
                    end else if (in_byte == rbap_pkg::CH_CR && dig_reg) begin
                        phase_next = PH_COUNT_LF;
                    end else err_next = rbap_pkg::ST_BAD_COUNT;
                end
                PH_COUNT_LF: begin
                    if (in_byte == rbap_pkg::CH_LF)
                        phase_next = (dcount_reg == '0) ? PH_IGNORE : PH_DOLLAR;
                    else err_next = rbap_pkg::ST_BAD_COUNT;
                end
                PH_DOLLAR: begin
                    if (in_byte == rbap_pkg::CH_DOLLAR) begin
                        phase_next = PH_LEN; dlen_next = '0; dig_next = 1'b0;
                    end else err_next = rbap_pkg::ST_NOT_DOLLAR;
                end
                PH_LEN: begin
                    if (is_dig) begin
                        dlen_next = lprod[LENGTH_BITS-1:0];
                        dig_next = 1'b1;
                        if (lprod[LENGTH_BITS+3:LENGTH_BITS] != '0)
                            err_next = rbap_pkg::ST_BAD_LENGTH;
                    end else if (in_byte == rbap_pkg::CH_CR) begin
                        if (dig_reg) phase_next = PH_LEN_LF;
                        else err_next = rbap_pkg::ST_BAD_LENGTH;
                    end else if (in_byte == rbap_pkg::CH_LF) begin
                        err_next = rbap_pkg::ST_FORMAT;
                    end else err_next = rbap_pkg::ST_BAD_LENGTH;
                end
                PH_LEN_LF: begin
                    if (in_byte == rbap_pkg::CH_LF) begin
                        phase_next = PH_DATA; rlen_next = '0;
                    end else err_next = rbap_pkg::ST_FORMAT;
                end
                PH_DATA: begin
                    if (in_byte == rbap_pkg::CH_CR) phase_next = PH_DATA_LF;
                    else if (in_byte == rbap_pkg::CH_LF) err_next = rbap_pkg::ST_FORMAT;
                    else begin
                        act_next.has_data = 1'b1;
                        act_next.kind = rbap_pkg::KIND_DATA;
                        act_next.data = in_byte;
                        if (!rlen_reg[LENGTH_BITS]) rlen_next = rlen_reg + 1'b1;
                    end
                end
                PH_DATA_LF: begin
                    if (in_byte != rbap_pkg::CH_LF) err_next = rbap_pkg::ST_FORMAT;
                    else if (rlen_reg != {1'b0, dlen_reg})
                        err_next = rbap_pkg::ST_LEN_MISMATCH;
                    else begin
                        act_next.has_data = 1'b1;
                        act_next.kind = rbap_pkg::KIND_END;
                        done_next = (done_reg + 1'b1) & CMAX;
                        phase_next = (done_next == dcount_reg) ? PH_DONE : PH_DOLLAR;
                    end
                end
                PH_DONE: err_next = rbap_pkg::ST_JUNK;
                PH_IGNORE: ;
                default: ;
            endcase
        end
        if (seen_next < 3'(rbap_pkg::MIN_BYTES)) fin_st = rbap_pkg::ST_FORMAT;
        else if (err_next != rbap_pkg::ST_OK) fin_st = err_next;
        else begin
            unique case (phase_next)
                PH_COUNT, PH_COUNT_LF: fin_st = rbap_pkg::ST_BAD_COUNT;
                PH_DOLLAR:             fin_st = rbap_pkg::ST_COUNT_MISMATCH;
                PH_DONE, PH_IGNORE:    fin_st = rbap_pkg::ST_OK;
                default:               fin_st = rbap_pkg::ST_FORMAT;
            endcase
        end
        if (in_final) begin
            act_next.has_status = 1'b1;
            act_next.status = fin_st;
            phase_next = PH_STAR; err_next = '0; seen_next = '0;
            dcount_next = '0; done_next = '0; dlen_next = '0;
            rlen_next = '0; dig_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_STAR; err_reg <= '0; seen_reg <= '0;
            dcount_reg <= '0; done_reg <= '0; dlen_reg <= '0;
            rlen_reg <= '0; dig_reg <= 1'b0; act_valid_reg <= 1'b0;
        end else begin
            if (in_ready) act_valid_reg <= take && (act_next.has_data || act_next.has_status);
            if (take) begin
                phase_reg <= phase_next; err_reg <= err_next; seen_reg <= seen_next;
                dcount_reg <= dcount_next; done_reg <= done_next;
                dlen_reg <= dlen_next; rlen_reg <= rlen_next; dig_reg <= dig_next;
            end
        end
        if (take) act_reg <= act_next;
    end

endmodule

// ----- hw/rtl/rbap_queue.sv -----
module rbap_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  rbap_pkg::action_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output rbap_pkg::action_t rd_data
);

    rbap_pkg::action_t mem_reg [2];
    logic              wp_reg, rp_reg;
    logic [1:0]        cnt_reg;
    logic              wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ----- hw/rtl/rbap_back.sv -----
module rbap_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              act_valid,
    output logic              act_ready,
    input  rbap_pkg::action_t act,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic       second_reg;
    logic       sel_status;
    logic       last;
    logic [7:0] b;
    logic [15:0] e;
    logic [3:0] s;

    // data result first, then status
    assign sel_status = !act.has_data || second_reg;
    assign last       = sel_status || !act.has_status;
    assign m_tvalid   = act_valid;
    assign act_ready  = m_tready && last;
    assign b = sel_status ? 8'h00 : act.data;
    assign e = sel_status ? 16'h0000 : act.element;
    assign s = sel_status ? act.status : rbap_pkg::ST_OK;
    assign m_tuser = sel_status ? rbap_pkg::KIND_STATUS : act.kind;
    assign m_tdata = {4'b0, s, e, b};
    assign m_tlast = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
        end else if (act_valid && m_tready) begin
            second_reg <= !last;
        end
    end

endmodule

// ----- sim/resp_bulk_array_parser_core_tb.sv -----
`timescale 1ns / 1ps

module resp_bulk_array_parser_core_tb;

    localparam int CNT_W = rbap_pkg::COUNT_BITS_DEF;
    localparam int LEN_W = rbap_pkg::LENGTH_BITS_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    typedef enum logic [3:0] {
        P_STAR, P_COUNT, P_COUNT_LF, P_DOLLAR, P_LEN, P_LEN_LF,
        P_DATA, P_DATA_LF, P_DONE, P_IGNORE
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
    } msg_byte_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] element;
        logic [3:0]  status;
        logic        run_end;
    } parse_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // in_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // out_byte, out_element, out_status, pad
    logic [1:0]  m_tuser;   // out_kind
    logic        m_tlast;

    resp_bulk_array_parser_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    msg_byte_t     pending_bytes[$];
    parse_result_t expected_results[$];
    int            mismatches;
    longint        cycles;
    bit            stim_done;

    // parser state mirror
    parse_phase_t    ph;
    logic [3:0]      err_latched;
    int unsigned     seen;
    logic [63:0]     decl_count;
    logic [63:0]     elem_done;
    logic [63:0]     decl_len;
    logic [63:0]     recv_len;
    bit              got_digit;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    function automatic void clear_parser();
        ph = P_STAR;
        err_latched = rbap_pkg::ST_OK;
        seen = 0;
        decl_count = 0;
        elem_done = 0;
        decl_len = 0;
        recv_len = 0;
        got_digit = 0;
    endfunction

    function automatic void push_result(logic [1:0] k, logic [7:0] d, logic [63:0] e,
                                        logic [3:0] st);
        parse_result_t r;
        r.kind = k;
        r.data = d;
        r.element = e[15:0];
        r.status = st;
        r.run_end = 0;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic bit is_dec(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [63:0] cmax;
        logic [63:0] lmax;
        cmax = (64'd1 << CNT_W) - 1;
        lmax = (64'd1 << LEN_W) - 1;
        case (ph)
            P_STAR: begin
                if (b == rbap_pkg::CH_STAR) begin
                    ph = P_COUNT; decl_count = 0; got_digit = 0;
                end else err_latched = rbap_pkg::ST_NO_STAR;
            end
            P_COUNT: begin
                if (is_dec(b)) begin
                    decl_count = decl_count * 10 + (b - 8'h30);
                    got_digit = 1;
                    if (decl_count > cmax) err_latched = rbap_pkg::ST_BAD_COUNT;
                end else if (b == rbap_pkg::CH_CR && got_digit) ph = P_COUNT_LF;
                else err_latched = rbap_pkg::ST_BAD_COUNT;
            end
            P_COUNT_LF: begin
                if (b == rbap_pkg::CH_LF) ph = (decl_count == 0) ? P_IGNORE : P_DOLLAR;
                else err_latched = rbap_pkg::ST_BAD_COUNT;
            end
            P_DOLLAR: begin
                if (b == rbap_pkg::CH_DOLLAR) begin
                    ph = P_LEN; decl_len = 0; got_digit = 0;
                end else err_latched = rbap_pkg::ST_NOT_DOLLAR;
            end
            P_LEN: begin
                if (is_dec(b)) begin
                    decl_len = decl_len * 10 + (b - 8'h30);
                    got_digit = 1;
                    if (decl_len > lmax) err_latched = rbap_pkg::ST_BAD_LENGTH;
                end else if (b == rbap_pkg::CH_CR) begin
                    if (got_digit) ph = P_LEN_LF;
                    else err_latched = rbap_pkg::ST_BAD_LENGTH;
                end else if (b == rbap_pkg::CH_LF) err_latched = rbap_pkg::ST_FORMAT;
                else err_latched = rbap_pkg::ST_BAD_LENGTH;
            end
            P_LEN_LF: begin
                if (b == rbap_pkg::CH_LF) begin
                    ph = P_DATA; recv_len = 0;
                end else err_latched = rbap_pkg::ST_FORMAT;
            end
            P_DATA: begin
                if (b == rbap_pkg::CH_CR) ph = P_DATA_LF;
                else if (b == rbap_pkg::CH_LF) err_latched = rbap_pkg::ST_FORMAT;
                else begin
                    push_result(rbap_pkg::KIND_DATA, b, elem_done, rbap_pkg::ST_OK);
                    if (recv_len <= lmax) recv_len++;
                end
            end
            P_DATA_LF: begin
                if (b != rbap_pkg::CH_LF) err_latched = rbap_pkg::ST_FORMAT;
                else if (recv_len != decl_len) err_latched = rbap_pkg::ST_LEN_MISMATCH;
                else begin
                    push_result(rbap_pkg::KIND_END, 8'h00, elem_done, rbap_pkg::ST_OK);
                    elem_done = (elem_done + 1) & cmax;
                    ph = (elem_done == decl_count) ? P_DONE : P_DOLLAR;
                end
            end
            P_DONE: err_latched = rbap_pkg::ST_JUNK;
            default: ;
        endcase
    endfunction

    function automatic logic [3:0] final_status();
        if (seen < rbap_pkg::MIN_BYTES) return rbap_pkg::ST_FORMAT;
        if (err_latched != rbap_pkg::ST_OK) return err_latched;
        case (ph)
            P_COUNT, P_COUNT_LF: return rbap_pkg::ST_BAD_COUNT;
            P_DOLLAR: return rbap_pkg::ST_COUNT_MISMATCH;
            P_DONE, P_IGNORE: return rbap_pkg::ST_OK;
            default: return rbap_pkg::ST_FORMAT;
        endcase
    endfunction

    function automatic void predict_request(msg_byte_t it);
        int before_n;
        before_n = expected_results.size();
        if (seen < rbap_pkg::MIN_BYTES) seen++;
        if (err_latched == rbap_pkg::ST_OK) parse_byte(it.byte_val);
        if (it.last) begin
            push_result(rbap_pkg::KIND_STATUS, 8'h00, 64'd0, final_status());
            clear_parser();
        end
        if (expected_results.size() > before_n)
            expected_results[expected_results.size() - 1].run_end = 1;
    endfunction

    // message builders
    task automatic add_raw(input logic [7:0] b, input bit last);
        msg_byte_t it;
        it.byte_val = b;
        it.last = last;
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    task automatic add_str(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            add_raw(s[i], last_at_end && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] rand_payload();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == rbap_pkg::CH_CR || b == rbap_pkg::CH_LF);
        return b;
    endfunction

    // well-formed message with optional corruption
    task automatic add_message(input int n_elem, input int corrupt);
        string hdr;
        msg_byte_t it;
        int base;
        int len;
        base = pending_bytes.size();
        hdr = $sformatf("*%0d\r\n", n_elem);
        add_str(hdr, 0);
        for (int e = 0; e < n_elem; e++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            add_str($sformatf("$%0d\r\n", len), 0);
            for (int i = 0; i < len; i++) add_raw(rand_payload(), 0);
            add_str("\r\n", 0);
        end
        if (corrupt == 1) begin
            it.byte_val = 8'($urandom_range(0, 255));
            it.last = 0;
            pending_bytes[$urandom_range(base, pending_bytes.size() - 1)] = it;
        end else if (corrupt == 2 && pending_bytes.size() - base > 1) begin
            pending_bytes = pending_bytes[0:$urandom_range(base, pending_bytes.size() - 2)];
        end else if (corrupt == 3) begin
            add_raw(8'($urandom_range(0, 255)), 0);
        end
        if (pending_bytes.size() == base) add_raw(8'($urandom_range(0, 255)), 0);
        pending_bytes[$].last = 1;
    endtask

    initial begin
        clear_parser();
        mismatches = 0;
        stim_done = 0;
        // directed
        add_str("*1\r\n$3\r\nabc\r\n", 1);
        add_str("*0\r\nxyz", 1);
        add_str("*2", 1);
        add_str("+1\r\n", 1);
        add_str("*1x\r\n", 1);
        add_str("*70000\r\n", 1);
        add_str("*1\r\n#3\r\n", 1);
        add_str("*1\r\n$4294967296\r\n", 1);
        add_str("*1\r\n$\r\n", 1);
        add_str("*1\r\n$2\nab", 1);
        add_str("*1\r\n$2\rXab\r\n", 1);
        add_str("*1\r\n$2\r\na\nb\r\n", 1);
        add_str("*1\r\n$2\r\nabc\r\n", 1);
        add_str("*1\r\n$1\r\na\rX", 1);
        add_str("*1\r\n$0\r\n\r\nJ", 1);
        add_str("*2\r\n$0\r\n\r\n", 1);
        add_str("*12", 1);
        add_str("*1\r\n$3\r\nab", 1);
        add_str("*\r\n", 1);
        add_raw(8'hFF, 1);
        add_raw(8'h00, 0); add_raw(8'hFF, 0); add_raw(8'h0D, 0); add_raw(8'h0A, 1);
        // random
        while (pending_bytes.size() < 1800) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 8)) add_raw(8'($urandom_range(0, 255)), 0);
                    pending_bytes[$].last = 1;
                end
                1, 2: add_message($urandom_range(0, 4), $urandom_range(1, 3));
                default: add_message($urandom_range(1, 4), 0);
            endcase
        end
        stim_done = 1;
    end

    // driver: bursts with gaps
    int burst_left;
    int gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= 0;
            s_tlast <= 0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                msg_byte_t it;
                it = pending_bytes.pop_front();
                predict_request(it);
            end
            if ((s_tvalid && !s_tready)) begin
                // hold request
            end else if (gap_left > 0) begin
                s_tvalid <= 0;
                gap_left <= gap_left - 1;
            end else if (pending_bytes.size() > 0) begin
                s_tvalid <= 1;
                s_tdata <= pending_bytes[0].byte_val;
                s_tlast <= pending_bytes[0].last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else burst_left <= burst_left - 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // receiver stall pattern
    logic [15:0] stall_lfsr;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            stall_lfsr <= 16'h1;
        end else begin
            stall_lfsr <= {stall_lfsr[14:0], stall_lfsr[15] ^ stall_lfsr[13]
                           ^ stall_lfsr[12] ^ stall_lfsr[10] ^ (stall_lfsr == 0)};
            if (stall_lfsr[15:12] >= 4'd12) m_tready <= 1;
            else if (stall_lfsr[11:9] == 3'd0) m_tready <= 0;
            else m_tready <= stall_lfsr[3] | stall_lfsr[5] | (stall_lfsr[8:6] == 3'd0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            parse_result_t want;
            parse_result_t got;
            got.data = m_tdata[7:0];
            got.element = m_tdata[23:8];
            got.status = m_tdata[27:24];
            got.kind = m_tuser;
            got.run_end = m_tlast;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        m_tready = 0;
        cycles = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        while (!(stim_done && pending_bytes.size() == 0 && !s_tvalid
                 && expected_results.size() == 0) && cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("[resp_bulk_array_parser_core] ERROR");
        end else begin
            repeat (20) @(posedge aclk);
            if (mismatches == 0) $display("[resp_bulk_array_parser_core] OK");
            else $display("[resp_bulk_array_parser_core] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rbap_pkg.sv
hw/rtl/rbap_front.sv
hw/rtl/rbap_queue.sv
hw/rtl/rbap_back.sv
hw/rtl/resp_bulk_array_parser_core.sv
sim/resp_bulk_array_parser_core_tb.sv
